[hdl/bdef_pkg.sv]
package bdef_pkg;

  localparam int unsigned BUTTON_COUNT = 5;
  localparam int unsigned RING_DEPTH   = 16;
  localparam int unsigned PTR_W        = $clog2(RING_DEPTH);
  localparam int unsigned PIN_W        = 5;
  localparam int unsigned EV_W         = 3;
  localparam int unsigned COUNT_W      = 4;
  localparam int unsigned MASK_W       = 5;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_TICK   = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } opcode_e;

  // one item entering the update logic
  typedef struct packed {
    logic             en;
    opcode_e          op;
    logic [PIN_W-1:0] pins;
  } step_t;

  // ring side of the result
  typedef struct packed {
    logic [EV_W-1:0]    ev;
    logic               ev_valid;
    logic [COUNT_W-1:0] count;
  } ring_res_t;

endpackage

[hdl/bdef_buttons.sv]
module bdef_buttons (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  bdef_pkg::step_t                      step_i,
  output logic [bdef_pkg::BUTTON_COUNT-1:0]    push_o,
  output logic [bdef_pkg::MASK_W-1:0]          mask_d_o
);
  import bdef_pkg::*;

  typedef enum logic [1:0] {
    PH_RELEASED = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_DOWN     = 2'd2,
    PH_UP       = 2'd3
  } phase_e;

  phase_e                  phase_q [BUTTON_COUNT];
  phase_e                  phase_d [BUTTON_COUNT];
  logic [BUTTON_COUNT-1:0] armed_q, armed_d;
  logic [BUTTON_COUNT-1:0] last_q, last_d;
  logic [BUTTON_COUNT-1:0] pin;

  // pins past the field read high
  always_comb begin
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      if (i < PIN_W) begin
        pin[i] = step_i.pins[i % PIN_W];
      end else begin
        pin[i] = 1'b1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      phase_d[i] = phase_q[i];
      armed_d[i] = armed_q[i];
      last_d[i]  = last_q[i];
      push_o[i]  = 1'b0;
      if (step_i.en) begin
        unique case (step_i.op)
          OP_SAMPLE: begin
            if (last_q[i] && !pin[i] && !armed_q[i]) begin
              phase_d[i] = PH_DOWN;
              armed_d[i] = 1'b1;
            end
            last_d[i] = pin[i];
          end
          OP_TICK: begin
            if (armed_q[i]) begin
              unique case (phase_q[i])
                PH_DOWN: begin
                  if (!pin[i]) begin
                    push_o[i]  = 1'b1;
                    phase_d[i] = PH_PRESSED;
                  end else begin
                    phase_d[i] = PH_UP;
                    armed_d[i] = 1'b0;
                  end
                end
                PH_PRESSED: begin
                  if (pin[i]) phase_d[i] = PH_UP;
                end
                PH_UP: begin
                  if (pin[i]) begin
                    phase_d[i] = PH_RELEASED;
                    armed_d[i] = 1'b0;
                  end
                end
                PH_RELEASED: ;
              endcase
            end
          end
          OP_READ, OP_NOP: ;
        endcase
      end
    end
  end

  always_comb begin
    mask_d_o = '0;
    for (int i = 0; i < MASK_W; i++) begin
      if (i < BUTTON_COUNT) begin
        mask_d_o[i] = (phase_d[i % BUTTON_COUNT] == PH_PRESSED);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BUTTON_COUNT; i++) phase_q[i] <= PH_RELEASED;
      armed_q <= '0;
      last_q  <= '1;
    end else begin
      for (int i = 0; i < BUTTON_COUNT; i++) phase_q[i] <= phase_d[i];
      armed_q <= armed_d;
      last_q  <= last_d;
    end
  end

endmodule

[hdl/bdef_ring.sv]
module bdef_ring (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  bdef_pkg::step_t                    step_i,
  input  logic [bdef_pkg::BUTTON_COUNT-1:0]  push_i,
  output bdef_pkg::ring_res_t                res_o
);
  import bdef_pkg::*;

  logic [EV_W-1:0]  store_q [RING_DEPTH];
  logic [EV_W-1:0]  store_d [RING_DEPTH];
  logic [PTR_W-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [PTR_W:0]   diff;

  function automatic logic [PTR_W-1:0] inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // pushes go in ascending button order; a full ring drops its oldest word
  always_comb begin
    store_d      = store_q;
    wp_d         = wp_q;
    rp_d         = rp_q;
    res_o.ev       = '0;
    res_o.ev_valid = 1'b0;
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      if (push_i[i]) begin
        store_d[wp_d] = EV_W'(i);
        wp_d          = inc(wp_d);
        if (wp_d == rp_d) rp_d = inc(rp_d);
      end
    end
    if (step_i.en && step_i.op == OP_READ && wp_q != rp_q) begin
      res_o.ev       = store_q[rp_q];
      res_o.ev_valid = 1'b1;
      rp_d           = inc(rp_q);
    end
    if (wp_d >= rp_d) begin
      diff = {1'b0, wp_d} - {1'b0, rp_d};
    end else begin
      diff = {1'b0, wp_d} + (PTR_W+1)'(RING_DEPTH) - {1'b0, rp_d};
    end
    res_o.count = COUNT_W'(diff);
  end

  always_ff @(posedge clk_i) begin
    store_q <= store_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
    end else begin
      wp_q <= wp_d;
      rp_q <= rp_d;
    end
  end

endmodule

[hdl/button_debounce_event_fifo_top.sv]
// channel | signals                                  | direction
// --------+------------------------------------------+----------
// in      | in_valid_i, in_ready_o, opcode_i,        | input
//         | pin_levels_i                             |
// out     | out_valid_o, out_ready_i, event_button_o,| output
//         | event_valid_o, queued_count_o,           |
//         | pressed_mask_o                           |
//
// One word in per cycle unless the result stalls, one result word per
// input word: input register, then the combinational button/ring update
// into the result register. All five button machines and every ring push
// of a tick settle in that one update. Reset clears button phases, tick
// arms and ring pointers and sets edge memory high at once; ring entries
// are not cleared and are never read before written. A stalled result
// holds the result and a full input register; in_ready_o drops only then.
module button_debounce_event_fifo_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   opcode_i,
  input  logic [bdef_pkg::PIN_W-1:0]   pin_levels_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [bdef_pkg::EV_W-1:0]    event_button_o,
  output logic                         event_valid_o,
  output logic [bdef_pkg::COUNT_W-1:0] queued_count_o,
  output logic [bdef_pkg::MASK_W-1:0]  pressed_mask_o
);
  import bdef_pkg::*;

  // input stage
  logic             in_valid_q;
  logic [1:0]       op_q;
  logic [PIN_W-1:0] pins_q;

  // result stage
  logic               out_valid_q;
  logic [EV_W-1:0]    ev_q;
  logic               ev_valid_q;
  logic [COUNT_W-1:0] count_q;
  logic [MASK_W-1:0]  mask_q;

  logic                    advance;
  step_t                   step;
  logic [BUTTON_COUNT-1:0] push;
  logic [MASK_W-1:0]       mask_d;
  ring_res_t               ring_res;

  // result slot free or draining this cycle
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;

  assign step.en   = in_valid_q && advance;
  assign step.op   = opcode_e'(op_q);
  assign step.pins = pins_q;

  bdef_buttons u_buttons (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .push_o   (push),
    .mask_d_o (mask_d)
  );

  bdef_ring u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .push_i (push),
    .res_o  (ring_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (advance) out_valid_q <= in_valid_q;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q   <= opcode_i;
      pins_q <= pin_levels_i;
    end
    if (step.en) begin
      ev_q       <= ring_res.ev;
      ev_valid_q <= ring_res.ev_valid;
      count_q    <= ring_res.count;
      mask_q     <= mask_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_button_o = ev_q;
  assign event_valid_o  = ev_valid_q;
  assign queued_count_o = count_q;
  assign pressed_mask_o = mask_q;

endmodule

[hdl/bdef_checker.sv]
module bdef_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [bdef_pkg::EV_W-1:0]    event_button_o,
  input logic                         event_valid_o,
  input logic [bdef_pkg::COUNT_W-1:0] queued_count_o,
  input logic [bdef_pkg::MASK_W-1:0]  pressed_mask_o
);
  import bdef_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(event_button_o)
      && $stable(event_valid_o) && $stable(queued_count_o)
      && $stable(pressed_mask_o))
    else $error("result word changed while stalled");

  // input only back-pressured by a stalled result
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output stall");

  // a pop leaves at most depth minus two words queued
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_valid_o |-> queued_count_o != {COUNT_W{1'b1}})
    else $error("count too high after a pop");

  a_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !event_valid_o |-> event_button_o == '0)
    else $error("event index without an event");

endmodule

bind button_debounce_event_fifo_top bdef_checker u_bdef_checker (.*);
